### design/lrr_pkg.sv
// lrr_pkg: shared types and codes for the line rectangle rasterizer
// used by lrr_setup, lrr_step and line_rect_rasterizer_unit; no dependencies
package lrr_pkg;

  // item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // line walking modes
  localparam logic [1:0] MODE_HORZ = 2'd0;
  localparam logic [1:0] MODE_VERT = 2'd1;
  localparam logic [1:0] MODE_XMAJ = 2'd2;
  localparam logic [1:0] MODE_YMAJ = 2'd3;

  // rectangle edge width on the result channel
  localparam int unsigned RECT_W = 18;

  // thickness and color widths
  localparam int unsigned THICK_W = 8;
  localparam int unsigned COLOR_W = 32;

  // line control held between items
  typedef struct packed {
    logic       active;
    logic [1:0] mode;
    logic [1:0] signs;   // bit 0: x walks negative, bit 1: y walks negative
  } line_ctrl_t;

  // what one step item produces
  typedef struct packed {
    logic emit;
    logic last;
  } step_stat_t;

endpackage

### design/lrr_setup.sv
// lrr_setup: decodes a load item into the initial line state
// depends on lrr_pkg
module lrr_setup #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic signed [COORD_WIDTH-1:0]   start_x_i,
  input  logic signed [COORD_WIDTH-1:0]   start_y_i,
  input  logic signed [COORD_WIDTH-1:0]   delta_x_i,
  input  logic signed [COORD_WIDTH-1:0]   delta_y_i,
  input  logic [lrr_pkg::THICK_W-1:0]     thickness_i,
  output logic signed [COORD_WIDTH:0]     cur_x_o,
  output logic signed [COORD_WIDTH:0]     cur_y_o,
  output logic signed [COORD_WIDTH:0]     end_x_o,
  output logic signed [COORD_WIDTH:0]     end_y_o,
  output logic [COORD_WIDTH-1:0]          adx_o,
  output logic [COORD_WIDTH-1:0]          ady_o,
  output logic signed [COORD_WIDTH:0]     err_o,
  output logic [COORD_WIDTH-1:0]          steps_o,
  output logic [lrr_pkg::THICK_W-1:0]     width_o,
  output lrr_pkg::line_ctrl_t             ctrl_o
);

  localparam int unsigned CW = COORD_WIDTH;

  logic signed [CW:0] sx_ext, sy_ext, dx_ext, dy_ext;
  logic signed [CW:0] neg_dx, neg_dy;
  logic [CW-1:0]      adx, ady, major;
  logic               dx_zero, dy_zero, x_major;

  // sign extend the coordinates by one bit
  assign sx_ext = {start_x_i[CW-1], start_x_i};
  assign sy_ext = {start_y_i[CW-1], start_y_i};
  assign dx_ext = {delta_x_i[CW-1], delta_x_i};
  assign dy_ext = {delta_y_i[CW-1], delta_y_i};

  // end point
  assign cur_x_o = sx_ext;
  assign cur_y_o = sy_ext;
  assign end_x_o = sx_ext + dx_ext;
  assign end_y_o = sy_ext + dy_ext;

  // magnitudes of the deltas
  assign neg_dx = -dx_ext;
  assign neg_dy = -dy_ext;
  assign adx    = dx_ext[CW] ? neg_dx[CW-1:0] : dx_ext[CW-1:0];
  assign ady    = dy_ext[CW] ? neg_dy[CW-1:0] : dy_ext[CW-1:0];
  assign adx_o  = adx;
  assign ady_o  = ady;

  assign dx_zero = (delta_x_i == '0);
  assign dy_zero = (delta_y_i == '0);
  assign x_major = (adx >= ady);
  assign major   = x_major ? adx : ady;

  // zero thickness counts as one pixel
  assign width_o = (thickness_i == '0) ? lrr_pkg::THICK_W'(1) : thickness_i;

  // mode selection and error seed at half the major span
  always_comb begin
    ctrl_o.active = 1'b1;
    ctrl_o.signs  = {dy_ext[CW], dx_ext[CW]};
    steps_o       = '0;
    err_o         = '0;
    if (dy_zero) begin
      ctrl_o.mode = lrr_pkg::MODE_HORZ;
    end else if (dx_zero) begin
      ctrl_o.mode = lrr_pkg::MODE_VERT;
    end else begin
      ctrl_o.mode = x_major ? lrr_pkg::MODE_XMAJ : lrr_pkg::MODE_YMAJ;
      steps_o     = major;
      err_o       = {2'b00, major[CW-1:1]};
    end
  end

endmodule

### design/lrr_step.sv
// lrr_step: one step of the line walk, gives a rectangle and the next line state
// depends on lrr_pkg
module lrr_step #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  lrr_pkg::line_ctrl_t             ctrl_i,
  input  logic signed [COORD_WIDTH:0]     cur_x_i,
  input  logic signed [COORD_WIDTH:0]     cur_y_i,
  input  logic signed [COORD_WIDTH:0]     end_x_i,
  input  logic signed [COORD_WIDTH:0]     end_y_i,
  input  logic [COORD_WIDTH-1:0]          adx_i,
  input  logic [COORD_WIDTH-1:0]          ady_i,
  input  logic signed [COORD_WIDTH:0]     err_i,
  input  logic [COORD_WIDTH-1:0]          steps_i,
  input  logic [lrr_pkg::THICK_W-1:0]     width_i,
  output logic signed [COORD_WIDTH+1:0]   rect_l_o,
  output logic signed [COORD_WIDTH+1:0]   rect_t_o,
  output logic signed [COORD_WIDTH+1:0]   rect_r_o,
  output logic signed [COORD_WIDTH+1:0]   rect_b_o,
  output lrr_pkg::step_stat_t             stat_o,
  output logic                            active_o,
  output logic signed [COORD_WIDTH:0]     cur_x_o,
  output logic signed [COORD_WIDTH:0]     cur_y_o,
  output logic signed [COORD_WIDTH:0]     err_o,
  output logic [COORD_WIDTH-1:0]          steps_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned IW = COORD_WIDTH + 2;

  logic signed [IW-1:0] cx_w, cy_w, ex_w, ey_w, w_w, one_w;
  logic signed [IW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [CW:0]   step_x, step_y, e1;
  logic [CW-1:0]        minor_amt, major_amt;
  logic                 straight, x_walk, take, last;

  // widen operands for edge arithmetic
  assign cx_w  = {cur_x_i[CW], cur_x_i};
  assign cy_w  = {cur_y_i[CW], cur_y_i};
  assign ex_w  = {end_x_i[CW], end_x_i};
  assign ey_w  = {end_y_i[CW], end_y_i};
  assign w_w   = {{(IW-lrr_pkg::THICK_W){1'b0}}, width_i};
  assign one_w = {{(IW-1){1'b0}}, 1'b1};

  // endpoint ordering for straight lines
  assign lo_x = (cx_w < ex_w) ? cx_w : ex_w;
  assign hi_x = (cx_w < ex_w) ? ex_w : cx_w;
  assign lo_y = (cy_w < ey_w) ? cy_w : ey_w;
  assign hi_y = (cy_w < ey_w) ? ey_w : cy_w;

  // rectangle edges
  always_comb begin
    case (ctrl_i.mode)
      lrr_pkg::MODE_HORZ: begin
        rect_l_o = lo_x;
        rect_t_o = cy_w;
        rect_r_o = hi_x + one_w;
        rect_b_o = cy_w + w_w;
      end
      lrr_pkg::MODE_VERT: begin
        rect_l_o = cx_w;
        rect_t_o = lo_y;
        rect_r_o = cx_w + w_w;
        rect_b_o = hi_y + one_w;
      end
      lrr_pkg::MODE_XMAJ: begin
        rect_l_o = cx_w;
        rect_t_o = cy_w;
        rect_r_o = cx_w + one_w;
        rect_b_o = cy_w + w_w;
      end
      default: begin
        rect_l_o = cx_w;
        rect_t_o = cy_w;
        rect_r_o = cx_w + w_w;
        rect_b_o = cy_w + one_w;
      end
    endcase
  end

  assign straight = (ctrl_i.mode == lrr_pkg::MODE_HORZ) ||
                    (ctrl_i.mode == lrr_pkg::MODE_VERT);
  assign last     = straight || (steps_i == '0);

  assign stat_o.emit = ctrl_i.active;
  assign stat_o.last = last;

  // bresenham error update
  assign x_walk    = (ctrl_i.mode == lrr_pkg::MODE_XMAJ);
  assign minor_amt = x_walk ? ady_i : adx_i;
  assign major_amt = x_walk ? adx_i : ady_i;
  assign e1        = err_i - {1'b0, minor_amt};
  assign take      = e1[CW];
  assign err_o     = take ? (e1 + {1'b0, major_amt}) : e1;

  // unit steps in the walk direction
  assign step_x = ctrl_i.signs[0] ? {(CW+1){1'b1}} : {{CW{1'b0}}, 1'b1};
  assign step_y = ctrl_i.signs[1] ? {(CW+1){1'b1}} : {{CW{1'b0}}, 1'b1};

  assign cur_x_o = (x_walk || take) ? (cur_x_i + step_x) : cur_x_i;
  assign cur_y_o = (!x_walk || take) ? (cur_y_i + step_y) : cur_y_i;

  assign active_o = !last;
  assign steps_o  = last ? steps_i : (steps_i - {{(CW-1){1'b0}}, 1'b1});

endmodule

### design/line_rect_rasterizer_unit.sv
// line_rect_rasterizer_unit: top level, input register, line state and result register
// depends on lrr_pkg, lrr_setup and lrr_step
//
//  channel  signals                              direction  payload
//  in       in_valid_i / in_stall_o              sink       func, start, delta, thickness, color
//  out      out_valid_o / out_stall_i            source     rectangle edges, fill_color, last
//
// one item per cycle sustained while out_stall_i is low: an item sits in the input register,
// where the line state update and the rectangle are computed in a single pass
// a result is loaded into the output register at the edge its item leaves the input register
// in_stall_o rises only while the input register holds an item and the result register is
// full and stalled
// reset clears the line state to idle and empties both registers
module line_rect_rasterizer_unit #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 func_i,
  input  logic signed [COORD_WIDTH-1:0]        start_x_i,
  input  logic signed [COORD_WIDTH-1:0]        start_y_i,
  input  logic signed [COORD_WIDTH-1:0]        delta_x_i,
  input  logic signed [COORD_WIDTH-1:0]        delta_y_i,
  input  logic [lrr_pkg::THICK_W-1:0]          thickness_i,
  input  logic [lrr_pkg::COLOR_W-1:0]          color_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [lrr_pkg::RECT_W-1:0]    left_o,
  output logic signed [lrr_pkg::RECT_W-1:0]    top_o,
  output logic signed [lrr_pkg::RECT_W-1:0]    right_o,
  output logic signed [lrr_pkg::RECT_W-1:0]    bottom_o,
  output logic [lrr_pkg::COLOR_W-1:0]          fill_color_o,
  output logic                                 last_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned IW = COORD_WIDTH + 2;
  localparam int unsigned RW = lrr_pkg::RECT_W;
  localparam int unsigned WW = (IW > RW) ? IW : RW;

  // input register
  logic                          s1_valid_q;
  logic                          s1_func_q;
  logic signed [CW-1:0]          s1_sx_q, s1_sy_q, s1_dx_q, s1_dy_q;
  logic [lrr_pkg::THICK_W-1:0]   s1_thick_q;
  logic [lrr_pkg::COLOR_W-1:0]   s1_color_q;

  // line state
  lrr_pkg::line_ctrl_t           ctrl_q;
  logic signed [CW:0]            cur_x_q, cur_y_q, end_x_q, end_y_q, err_q;
  logic [CW-1:0]                 adx_q, ady_q, steps_q;
  logic [lrr_pkg::THICK_W-1:0]   width_q;
  logic [lrr_pkg::COLOR_W-1:0]   color_q;

  // result register
  logic                          out_valid_q;
  logic signed [RW-1:0]          left_q, top_q, right_q, bottom_q;
  logic [lrr_pkg::COLOR_W-1:0]   fill_q;
  logic                          last_q;

  // setup and step results
  lrr_pkg::line_ctrl_t           ld_ctrl;
  logic signed [CW:0]            ld_cur_x, ld_cur_y, ld_end_x, ld_end_y, ld_err;
  logic [CW-1:0]                 ld_adx, ld_ady, ld_steps;
  logic [lrr_pkg::THICK_W-1:0]   ld_width;

  logic signed [IW-1:0]          rect_l, rect_t, rect_r, rect_b;
  lrr_pkg::step_stat_t           st_stat;
  logic                          st_active;
  logic signed [CW:0]            st_cur_x, st_cur_y, st_err;
  logic [CW-1:0]                 st_steps;

  logic                          advance, in_take, do_load, do_step;
  logic signed [WW-1:0]          l_ext, t_ext, r_ext, b_ext;

  // handshake
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign do_load    = advance && (s1_func_q == lrr_pkg::FUNC_LOAD);
  assign do_step    = advance && (s1_func_q == lrr_pkg::FUNC_STEP) && ctrl_q.active;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take || advance) begin
      s1_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_func_q  <= func_i;
      s1_sx_q    <= start_x_i;
      s1_sy_q    <= start_y_i;
      s1_dx_q    <= delta_x_i;
      s1_dy_q    <= delta_y_i;
      s1_thick_q <= thickness_i;
      s1_color_q <= color_i;
    end
  end

  lrr_setup #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_setup (
    .start_x_i  (s1_sx_q),
    .start_y_i  (s1_sy_q),
    .delta_x_i  (s1_dx_q),
    .delta_y_i  (s1_dy_q),
    .thickness_i(s1_thick_q),
    .cur_x_o    (ld_cur_x),
    .cur_y_o    (ld_cur_y),
    .end_x_o    (ld_end_x),
    .end_y_o    (ld_end_y),
    .adx_o      (ld_adx),
    .ady_o      (ld_ady),
    .err_o      (ld_err),
    .steps_o    (ld_steps),
    .width_o    (ld_width),
    .ctrl_o     (ld_ctrl)
  );

  lrr_step #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_step (
    .ctrl_i  (ctrl_q),
    .cur_x_i (cur_x_q),
    .cur_y_i (cur_y_q),
    .end_x_i (end_x_q),
    .end_y_i (end_y_q),
    .adx_i   (adx_q),
    .ady_i   (ady_q),
    .err_i   (err_q),
    .steps_i (steps_q),
    .width_i (width_q),
    .rect_l_o(rect_l),
    .rect_t_o(rect_t),
    .rect_r_o(rect_r),
    .rect_b_o(rect_b),
    .stat_o  (st_stat),
    .active_o(st_active),
    .cur_x_o (st_cur_x),
    .cur_y_o (st_cur_y),
    .err_o   (st_err),
    .steps_o (st_steps)
  );

  // line state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= '0;
      cur_x_q <= '0;
      cur_y_q <= '0;
      end_x_q <= '0;
      end_y_q <= '0;
      err_q   <= '0;
      adx_q   <= '0;
      ady_q   <= '0;
      steps_q <= '0;
      width_q <= lrr_pkg::THICK_W'(1);
      color_q <= '0;
    end else if (do_load) begin
      ctrl_q  <= ld_ctrl;
      cur_x_q <= ld_cur_x;
      cur_y_q <= ld_cur_y;
      end_x_q <= ld_end_x;
      end_y_q <= ld_end_y;
      err_q   <= ld_err;
      adx_q   <= ld_adx;
      ady_q   <= ld_ady;
      steps_q <= ld_steps;
      width_q <= ld_width;
      color_q <= s1_color_q;
    end else if (do_step) begin
      ctrl_q.active <= st_active;
      cur_x_q       <= st_cur_x;
      cur_y_q       <= st_cur_y;
      err_q         <= st_err;
      steps_q       <= st_steps;
    end
  end

  // wrap edges to the result width
  assign l_ext = WW'(rect_l);
  assign t_ext = WW'(rect_t);
  assign r_ext = WW'(rect_r);
  assign b_ext = WW'(rect_b);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= do_step || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step) begin
      left_q   <= l_ext[RW-1:0];
      top_q    <= t_ext[RW-1:0];
      right_q  <= r_ext[RW-1:0];
      bottom_q <= b_ext[RW-1:0];
      fill_q   <= color_q;
      last_q   <= st_stat.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign left_o       = left_q;
  assign top_o        = top_q;
  assign right_o      = right_q;
  assign bottom_o     = bottom_q;
  assign fill_color_o = fill_q;
  assign last_o       = last_q;

  // a load always leaves a line in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_load |=> ctrl_q.active)
    else $error("line not active after load");

  // the final rectangle ends the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_step && st_stat.last) |=> !ctrl_q.active)
    else $error("line still active after final rectangle");

  // straight lines give a single rectangle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_step && ((ctrl_q.mode == lrr_pkg::MODE_HORZ) ||
                 (ctrl_q.mode == lrr_pkg::MODE_VERT))) |-> st_stat.last)
    else $error("straight line rectangle without last flag");

  // every emitted rectangle covers at least one pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_step |-> ((rect_r > rect_l) && (rect_b > rect_t)))
    else $error("empty rectangle emitted");

  // a step while idle never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !do_load && !ctrl_q.active && !(out_valid_q && out_stall_i))
      |=> !out_valid_q)
    else $error("result from idle step");

endmodule
